// File: rtl/dbsg_pkg.sv
`timescale 1ns / 1ps

package dbsg_pkg;

    // Window-length register
    localparam int ORDER_W     = 4;
    localparam int ORDER_RESET = 4;
    localparam int TAIL_W      = 4;

    // Generator sequencer codes
    localparam int GEN_W = 3;
    localparam logic [GEN_W-1:0] GEN_CLEAR = 3'd0;  // zeroing edge counters
    localparam logic [GEN_W-1:0] GEN_INIT  = 3'd1;  // seed stack with node 0
    localparam logic [GEN_W-1:0] GEN_EVAL  = 3'd2;  // push or pop at stack top
    localparam logic [GEN_W-1:0] GEN_POPRD = 3'd3;  // new top returning from stack
    localparam logic [GEN_W-1:0] GEN_TAIL  = 3'd4;  // trailing zeros
    localparam logic [GEN_W-1:0] GEN_ONE   = 3'd5;  // order one: second bit
    localparam logic [GEN_W-1:0] GEN_DONE  = 3'd6;  // sequence exhausted

    typedef struct packed {
        logic bit_val;
        logic last;
        logic done;
    } ans_t;

endpackage

// File: rtl/de_bruijn_sequence_generator.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake         Payload
// -------   ---  ---------------   -----------------------------------
// s_        in   s_valid/s_ready   s_restart
// m_        out  m_valid/m_ready   m_seq_bit, m_last_bit, m_done_res
// cfg_      in   cfg_we (no wait)  cfg_wdata (window length)
//
// The Euler walk runs ahead of requests: each push is one EVAL step, each pop an
// EVAL step plus a POPRD step for the stack read that recovers the new top;
// trailing zeros and done answers take one step each. Throughput is set by the
// walk's push and pop steps. After reset, a restart transfer or a cfg write,
// the edge counters of all 2^(k-1) nodes (k = effective order) are zeroed and
// the stack is seeded; s_ready is low meanwhile. A stalled m_ side holds one
// result in the output register and one precomputed answer; the walk then waits
// at its next pop.

module de_bruijn_sequence_generator
    import dbsg_pkg::*;
#(
    parameter int MAX_ORDER = 12
) (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               cfg_we,
    input  logic [ORDER_W-1:0] cfg_wdata,

    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_restart,

    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_seq_bit,
    output logic               m_last_bit,
    output logic               m_done_res
);

    localparam int NW         = MAX_ORDER - 1;            // node width
    localparam int DW         = MAX_ORDER + 1;            // stack depth width
    localparam int NODE_CNT   = 1 << NW;
    localparam int STACK_SIZE = (1 << MAX_ORDER) + 1;

    // Clamp the register value to the supported window range.
    function automatic logic [ORDER_W-1:0] eff_order(input logic [ORDER_W-1:0] o);
        logic [ORDER_W-1:0] k;
        k = o;
        if (o == '0) begin
            k = ORDER_W'(1);
        end
        if (MAX_ORDER < (1 << ORDER_W) && int'(o) > MAX_ORDER) begin
            k = ORDER_W'(MAX_ORDER);
        end
        return k;
    endfunction

    function automatic logic [TAIL_W-1:0] tail_init(input logic [ORDER_W-1:0] k);
        return (k >= ORDER_W'(2)) ? TAIL_W'(k - ORDER_W'(2)) : '0;
    endfunction

    // ---------------------------------------------------------------- registers
    logic [ORDER_W-1:0] order_reg, order_next;
    logic [GEN_W-1:0]   gen_reg, gen_next;
    logic [NW-1:0]      clr_reg, clr_next;
    logic [NW-1:0]      top_reg, top_next;
    logic [DW-1:0]      depth_reg, depth_next;
    logic [TAIL_W-1:0]  tail_reg, tail_next;
    logic               fwd_reg, fwd_next;       // edge read bypass
    logic [1:0]         fwd_val_reg, fwd_val_next;
    logic               ans_valid_reg, ans_valid_next;
    ans_t               ans_reg, ans_next;
    logic               m_valid_reg, m_valid_next;
    ans_t               m_res_reg, m_res_next;

    // ---------------------------------------------------------------- memories
    logic [1:0]    edges_mem [NODE_CNT];
    logic [NW-1:0] stack_mem [STACK_SIZE];

    logic          edge_we;
    logic [NW-1:0] edge_waddr, edge_raddr;
    logic [1:0]    edge_wdata, edge_q;
    logic          stack_we;
    logic [DW-1:0] stack_waddr, stack_raddr;
    logic [NW-1:0] stack_wdata, stack_q;

    always_ff @(posedge aclk) begin
        if (edge_we) begin
            edges_mem[edge_waddr] <= edge_wdata;
        end
        edge_q <= edges_mem[edge_raddr];
    end

    always_ff @(posedge aclk) begin
        if (stack_we) begin
            stack_mem[stack_waddr] <= stack_wdata;
        end
        stack_q <= stack_mem[stack_raddr];
    end

    // ---------------------------------------------------------------- handshake
    logic consume, restart_xfer, slot_free;

    assign s_ready      = ans_valid_reg && (!m_valid_reg || m_ready);
    assign consume      = s_valid && s_ready && !s_restart;
    assign restart_xfer = s_valid && s_ready && s_restart;
    // room to produce the next answer this cycle
    assign slot_free    = !ans_valid_reg || consume;

    // ---------------------------------------------------------------- walk
    logic [ORDER_W-1:0] k_eff, k_new;
    logic [NW-1:0]      mask;
    logic [1:0]         used;
    logic               can_push;
    logic [NW-1:0]      new_top;
    logic [NW-1:0]      popped_top;
    logic               pop_last;

    assign k_eff    = eff_order(order_reg);
    assign mask     = ~({NW{1'b1}} << (k_eff - ORDER_W'(1)));
    // counter from memory, or the value written in the previous cycle
    assign used     = fwd_reg ? fwd_val_reg : edge_q;
    assign can_push = !used[1] && (depth_reg != DW'(STACK_SIZE));
    assign new_top  = NW'({top_reg, used[0]}) & mask;
    assign popped_top = stack_q & mask;
    assign pop_last = (depth_reg == DW'(1)) && (tail_reg == '0);

    always_comb begin
        order_next     = order_reg;
        gen_next       = gen_reg;
        clr_next       = clr_reg;
        top_next       = top_reg;
        depth_next     = depth_reg;
        tail_next      = tail_reg;
        fwd_next       = 1'b0;
        fwd_val_next   = fwd_val_reg;
        ans_valid_next = ans_valid_reg;
        ans_next       = ans_reg;
        k_new          = k_eff;

        edge_we     = 1'b0;
        edge_waddr  = top_reg;
        edge_wdata  = '0;
        edge_raddr  = top_reg;
        stack_we    = 1'b0;
        stack_waddr = depth_reg;
        stack_wdata = new_top;
        stack_raddr = '0;

        // answer taken; done answers repeat
        if (consume && gen_reg != GEN_DONE) begin
            ans_valid_next = 1'b0;
        end

        case (gen_reg)
            GEN_CLEAR: begin
                edge_we    = 1'b1;
                edge_waddr = clr_reg;
                edge_wdata = '0;
                if (clr_reg == mask) begin
                    gen_next = GEN_INIT;
                end else begin
                    clr_next = clr_reg + NW'(1);
                end
            end
            GEN_INIT: begin
                stack_we    = 1'b1;
                stack_waddr = '0;
                stack_wdata = '0;
                edge_raddr  = '0;
                if (k_eff == ORDER_W'(1)) begin
                    if (slot_free) begin
                        ans_valid_next = 1'b1;
                        ans_next       = '{bit_val: 1'b0, last: 1'b0, done: 1'b0};
                        gen_next       = GEN_ONE;
                    end
                end else begin
                    gen_next = GEN_EVAL;
                end
            end
            GEN_EVAL: begin
                if (can_push) begin
                    edge_we      = 1'b1;
                    edge_waddr   = top_reg;
                    edge_wdata   = used + 2'd1;
                    stack_we     = 1'b1;
                    stack_waddr  = depth_reg;
                    stack_wdata  = new_top;
                    top_next     = new_top;
                    depth_next   = depth_reg + DW'(1);
                    edge_raddr   = new_top;
                    fwd_next     = (new_top == top_reg);
                    fwd_val_next = used + 2'd1;
                end else if (slot_free) begin
                    ans_valid_next = 1'b1;
                    ans_next   = '{bit_val: top_reg[0], last: pop_last, done: 1'b0};
                    depth_next = depth_reg - DW'(1);
                    if (pop_last) begin
                        gen_next = GEN_DONE;
                    end else if (depth_reg == DW'(1)) begin
                        gen_next = GEN_TAIL;
                    end else begin
                        stack_raddr = depth_reg - DW'(2);
                        gen_next    = GEN_POPRD;
                    end
                end
                // else: stalled at a pop; re-read the counter fresh
            end
            GEN_POPRD: begin
                top_next   = popped_top;
                edge_raddr = popped_top;
                gen_next   = GEN_EVAL;
            end
            GEN_TAIL: begin
                if (slot_free) begin
                    ans_valid_next = 1'b1;
                    ans_next  = '{bit_val: 1'b0, last: (tail_reg == TAIL_W'(1)), done: 1'b0};
                    tail_next = tail_reg - TAIL_W'(1);
                    if (tail_reg == TAIL_W'(1)) begin
                        gen_next = GEN_DONE;
                    end
                end
            end
            GEN_ONE: begin
                if (slot_free) begin
                    ans_valid_next = 1'b1;
                    ans_next       = '{bit_val: 1'b1, last: 1'b1, done: 1'b0};
                    gen_next       = GEN_DONE;
                end
            end
            GEN_DONE: begin
                // the final bit stays put until it is taken
                if (slot_free) begin
                    ans_valid_next = 1'b1;
                    ans_next       = '{bit_val: 1'b0, last: 1'b0, done: 1'b1};
                end
            end
            default: begin
                gen_next = GEN_CLEAR;
                clr_next = '0;
            end
        endcase

        // restart: new window length on a cfg write, otherwise the current one
        if (cfg_we || restart_xfer) begin
            if (cfg_we) begin
                order_next = cfg_wdata;
                k_new      = eff_order(cfg_wdata);
            end
            gen_next       = GEN_CLEAR;
            clr_next       = '0;
            top_next       = '0;
            depth_next     = DW'(1);
            tail_next      = tail_init(k_new);
            fwd_next       = 1'b0;
            ans_valid_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------- output
    always_comb begin
        m_res_next   = m_res_reg;
        m_valid_next = m_valid_reg;
        if (consume) begin
            m_res_next   = ans_reg;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            order_reg     <= ORDER_W'(ORDER_RESET);
            gen_reg       <= GEN_CLEAR;
            clr_reg       <= '0;
            top_reg       <= '0;
            depth_reg     <= DW'(1);
            tail_reg      <= tail_init(eff_order(ORDER_W'(ORDER_RESET)));
            fwd_reg       <= 1'b0;
            ans_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            order_reg     <= order_next;
            gen_reg       <= gen_next;
            clr_reg       <= clr_next;
            top_reg       <= top_next;
            depth_reg     <= depth_next;
            tail_reg      <= tail_next;
            fwd_reg       <= fwd_next;
            ans_valid_reg <= ans_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        fwd_val_reg <= fwd_val_next;
        ans_reg     <= ans_next;
        m_res_reg   <= m_res_next;
    end

    assign m_valid    = m_valid_reg;
    assign m_seq_bit  = m_res_reg.bit_val;
    assign m_last_bit = m_res_reg.last;
    assign m_done_res = m_res_reg.done;

endmodule
